// ----- rtl/rhht_pkg.sv -----
// Package for the Robin Hood hash table core: sizes, codes and payload types.
// Used by the core and its testbench; depends on nothing.
`default_nettype none
package rhht_pkg;
   localparam int CAPACITY   = 64;
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int HASH_BITS  = 32;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_INSERTED  = 3'd1;
   localparam logic [2:0] ST_REPLACED  = 3'd2;
   localparam logic [2:0] ST_REMOVED   = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] key;
      logic [31:0] key_hash;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] value_out;
      logic [5:0]  slot_index;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [HASH_BITS-1:0]  hash;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } slot_type;
endpackage
`default_nettype wire

// ----- rtl/robin_hood_hash_table_core.sv -----
// Top level of the Robin Hood hash table core: sequencer and slot RAM.
// Depends on rhht_pkg and rhht_ram.
//
// Usage: a request (lookup, insert or replace, remove) is a transfer on the
// req_ channel; exactly one result follows on the rsp_ channel. The block
// handles one request at a time: req_ready is low from the transfer of a
// request until its result has been taken. Each probed slot passes through
// S_SEARCH, which addresses the slot RAM, and S_SREAD, which examines its
// registered read. Insert displacement walks further slots through S_PLACE
// and S_PREAD, and the remove back-shift walks slots through S_ERASE and
// S_EREAD; the single slot port is why each slot needs an address step and
// a read step. An unused operation code answers in the cycle after its
// transfer. After reset a clearing pass writes every slot empty, during
// which req_ready stays low. When the receiver stalls, the result is held
// in the output register and no new request is taken until it leaves.
`default_nettype none
module robin_hood_hash_table_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rhht_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rhht_pkg::rsp_type      rsp_data
);
   localparam int IB = rhht_pkg::IDX_BITS;
   localparam int CB = rhht_pkg::CNT_BITS;
   localparam int SW = $bits(rhht_pkg::slot_type);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_SEARCH = 4'd2;
   localparam logic [3:0] S_SREAD  = 4'd3;
   localparam logic [3:0] S_PLACE  = 4'd4;
   localparam logic [3:0] S_PREAD  = 4'd5;
   localparam logic [3:0] S_ERASE  = 4'd6;
   localparam logic [3:0] S_EREAD  = 4'd7;
   localparam logic [3:0] S_RESP   = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [CB-1:0] count_ff, count_in;
   logic [1:0]  op_ff, op_in;
   logic [31:0] key_ff, key_in, hash_ff, hash_in, val_ff, val_in;
   logic [IB-1:0] idx_ff, idx_in, stop_ff, stop_in;
   logic [CB-1:0] dist_ff, dist_in;
   logic [CB-1:0] steps_ff, steps_in;
   rhht_pkg::rsp_type rsp_ff, rsp_in;

   logic               ram_we;
   logic [IB-1:0]      ram_addr;
   rhht_pkg::slot_type slot_wd, slot_rd;

   logic          slot_empty;
   logic [IB-1:0] slot_home, slot_sd, nxt_idx;
   logic [31:0]   req_hash;

   rhht_ram #(.WIDTH(SW), .DEPTH(rhht_pkg::CAPACITY)) u_slots (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(slot_wd), .rd_data(slot_rd));

   assign slot_empty = (slot_rd.hash == 32'd0);
   assign slot_home  = slot_rd.hash[IB-1:0];
   assign slot_sd    = idx_ff - slot_home;
   assign nxt_idx    = idx_ff + IB'(1);
   assign req_hash   = (req_data.key_hash == 32'd0) ? 32'd1 : req_data.key_hash;
   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign rsp_data   = rsp_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      hash_in  = hash_ff;
      val_in   = val_ff;
      idx_in   = idx_ff;
      stop_in  = stop_ff;
      dist_in  = dist_ff;
      steps_in = steps_ff;
      rsp_in   = rsp_ff;
      ram_we   = 1'b0;
      ram_addr = idx_ff;
      slot_wd.hash  = hash_ff;
      slot_wd.key   = key_ff;
      slot_wd.value = val_ff;
      case (state_ff)
         S_CLEAR: begin
            ram_we  = 1'b1;
            slot_wd = '0;
            idx_in  = nxt_idx;
            if (idx_ff == IB'(rhht_pkg::CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.operation;
               key_in   = req_data.key;
               hash_in  = req_hash;
               val_in   = req_data.value;
               idx_in   = req_hash[IB-1:0];
               dist_in  = '0;
               steps_in = '0;
               rsp_in.status      = rhht_pkg::ST_NOT_FOUND;
               rsp_in.value_out   = '0;
               rsp_in.slot_index  = '0;
               rsp_in.entry_count = count_ff;
               if (req_data.operation == rhht_pkg::OP_LOOKUP ||
                   req_data.operation == rhht_pkg::OP_INSERT ||
                   req_data.operation == rhht_pkg::OP_REMOVE) begin
                  state_in = S_SEARCH;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SEARCH: begin
            if (steps_ff == CB'(rhht_pkg::CAPACITY)) begin
               if (op_ff == rhht_pkg::OP_INSERT) begin
                  rsp_in.status = rhht_pkg::ST_FULL;
               end
               state_in = S_RESP;
            end else begin
               state_in = S_SREAD;
            end
         end
         S_SREAD: begin
            if (slot_empty || dist_ff > CB'(slot_sd)) begin
               if (op_ff == rhht_pkg::OP_INSERT) begin
                  if (count_ff >= CB'(rhht_pkg::CAPACITY)) begin
                     rsp_in.status = rhht_pkg::ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     rsp_in.status     = rhht_pkg::ST_INSERTED;
                     rsp_in.slot_index = idx_ff;
                     ram_we = 1'b1;
                     if (slot_empty) begin
                        count_in = count_ff + CB'(1);
                        rsp_in.entry_count = count_ff + CB'(1);
                        state_in = S_RESP;
                     end else begin
                        hash_in  = slot_rd.hash;
                        key_in   = slot_rd.key;
                        val_in   = slot_rd.value;
                        dist_in  = CB'(slot_sd) + CB'(1);
                        idx_in   = nxt_idx;
                        state_in = S_PLACE;
                     end
                  end
               end else begin
                  state_in = S_RESP;
               end
            end else if (slot_rd.hash == hash_ff && slot_rd.key == key_ff) begin
               rsp_in.value_out  = slot_rd.value;
               rsp_in.slot_index = idx_ff;
               case (op_ff)
                  rhht_pkg::OP_LOOKUP: begin
                     rsp_in.status = rhht_pkg::ST_FOUND;
                     state_in = S_RESP;
                  end
                  rhht_pkg::OP_INSERT: begin
                     rsp_in.status = rhht_pkg::ST_REPLACED;
                     ram_we = 1'b1;
                     state_in = S_RESP;
                  end
                  default: begin
                     rsp_in.status = rhht_pkg::ST_REMOVED;
                     stop_in  = idx_ff;
                     idx_in   = nxt_idx;
                     steps_in = '0;
                     count_in = count_ff - CB'(1);
                     rsp_in.entry_count = count_ff - CB'(1);
                     state_in = S_ERASE;
                  end
               endcase
            end else begin
               idx_in   = nxt_idx;
               dist_in  = dist_ff + CB'(1);
               steps_in = steps_ff + CB'(1);
               state_in = S_SEARCH;
            end
         end
         S_PLACE: begin
            state_in = S_PREAD;
         end
         S_PREAD: begin
            if (slot_empty) begin
               ram_we   = 1'b1;
               count_in = count_ff + CB'(1);
               rsp_in.entry_count = count_ff + CB'(1);
               state_in = S_RESP;
            end else if (dist_ff > CB'(slot_sd)) begin
               ram_we   = 1'b1;
               hash_in  = slot_rd.hash;
               key_in   = slot_rd.key;
               val_in   = slot_rd.value;
               dist_in  = CB'(slot_sd) + CB'(1);
               idx_in   = nxt_idx;
               state_in = S_PLACE;
            end else begin
               dist_in  = dist_ff + CB'(1);
               idx_in   = nxt_idx;
               state_in = S_PLACE;
            end
         end
         S_ERASE: begin
            state_in = S_EREAD;
         end
         S_EREAD: begin
            ram_we   = 1'b1;
            ram_addr = stop_ff;
            if (slot_empty || slot_sd == '0 || steps_ff == CB'(rhht_pkg::CAPACITY)) begin
               slot_wd  = '0;
               state_in = S_RESP;
            end else begin
               slot_wd  = slot_rd;
               stop_in  = idx_ff;
               idx_in   = nxt_idx;
               steps_in = steps_ff + CB'(1);
               state_in = S_ERASE;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      hash_ff  <= hash_in;
      val_ff   <= val_in;
      stop_ff  <= stop_in;
      dist_ff  <= dist_in;
      steps_ff <= steps_in;
      rsp_ff   <= rsp_in;
   end
endmodule
`default_nettype wire

// ----- rtl/rhht_ram.sv -----
// Generic single-port RAM with registered read.
// Stand-alone; used for the slot store of the hash table core.
`default_nettype none
module rhht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ----- dv/robin_hood_hash_table_core_tb.sv -----
// Testbench for the Robin Hood hash table core: directed table, a fill past capacity, then random traffic.
// Results are checked against an in-bench model of the table; depends on rhht_pkg.
`default_nettype none
module robin_hood_hash_table_core_tb;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM       = 1100;

   typedef struct {
      logic [1:0]  operation;
      logic [31:0] key;
      logic [31:0] key_hash;
      logic [31:0] value;
      bit          typed;
      logic [2:0]  status;
      logic [31:0] value_out;
      logic [5:0]  slot_index;
      logic [6:0]  entry_count;
   } directed_row;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   rhht_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   rhht_pkg::rsp_type rsp_data;

   logic [31:0] table_hash [rhht_pkg::CAPACITY];
   logic [31:0] table_key  [rhht_pkg::CAPACITY];
   logic [31:0] table_val  [rhht_pkg::CAPACITY];
   int          table_count;

   rhht_pkg::rsp_type pending_rsp[$];
   logic [31:0]       live_keys[$];
   int                mismatch_count = 0;
   int                idle_cycles = 0;
   bit                long_stall = 0;
   directed_row       rows[$];

   robin_hood_hash_table_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   function automatic int probe_distance(int idx, logic [31:0] h);
      int home;
      home = h % rhht_pkg::CAPACITY;
      return idx < home ? rhht_pkg::CAPACITY - home + idx : idx - home;
   endfunction

   function automatic logic [31:0] hash_of(logic [31:0] key);
      return key * 32'h9E3779B1 + 32'h7F4A7C15;
   endfunction

   function automatic rhht_pkg::rsp_type table_apply(rhht_pkg::req_type r);
      rhht_pkg::rsp_type o;
      logic [31:0]       h, hk, kk, vk, sh, tk, tv;
      int                i, d, pos, carry_dist, stop, nx;
      bit                found, has_pos;
      o = '0;
      o.status = rhht_pkg::ST_NOT_FOUND;
      h = (r.key_hash == 0) ? 32'd1 : r.key_hash;
      found = 0;
      has_pos = 0;
      pos = 0;
      if (r.operation != rhht_pkg::OP_NONE) begin
         i = h % rhht_pkg::CAPACITY;
         for (d = 0; d < rhht_pkg::CAPACITY; d++) begin
            sh = table_hash[i];
            if (sh == 0 || d > probe_distance(i, sh)) begin
               pos = i;
               has_pos = 1;
               break;
            end
            if (sh == h && table_key[i] == r.key) begin
               pos = i;
               has_pos = 1;
               found = 1;
               break;
            end
            i = (i + 1) % rhht_pkg::CAPACITY;
         end
         if (r.operation == rhht_pkg::OP_LOOKUP) begin
            if (found) begin
               o.status = rhht_pkg::ST_FOUND;
               o.value_out = table_val[pos];
               o.slot_index = 6'(pos);
            end
         end else if (r.operation == rhht_pkg::OP_INSERT) begin
            if (found) begin
               o.status = rhht_pkg::ST_REPLACED;
               o.value_out = table_val[pos];
               o.slot_index = 6'(pos);
               table_val[pos] = r.value;
            end else if (table_count >= rhht_pkg::CAPACITY || !has_pos) begin
               o.status = rhht_pkg::ST_FULL;
            end else begin
               o.status = rhht_pkg::ST_INSERTED;
               o.slot_index = 6'(pos);
               hk = h;
               kk = r.key;
               vk = r.value;
               i = pos;
               carry_dist = probe_distance(pos, hk);
               for (d = 0; d < rhht_pkg::CAPACITY; d++) begin
                  sh = table_hash[i];
                  if (sh == 0) begin
                     table_hash[i] = hk;
                     table_key[i] = kk;
                     table_val[i] = vk;
                     table_count++;
                     break;
                  end
                  if (carry_dist > probe_distance(i, sh)) begin
                     tk = table_key[i];
                     tv = table_val[i];
                     table_hash[i] = hk;
                     table_key[i] = kk;
                     table_val[i] = vk;
                     carry_dist = probe_distance(i, sh);
                     hk = sh;
                     kk = tk;
                     vk = tv;
                  end
                  i = (i + 1) % rhht_pkg::CAPACITY;
                  carry_dist++;
               end
            end
         end else if (found) begin
            o.status = rhht_pkg::ST_REMOVED;
            o.value_out = table_val[pos];
            o.slot_index = 6'(pos);
            stop = pos;
            nx = (pos + 1) % rhht_pkg::CAPACITY;
            table_hash[pos] = 0;
            for (d = 0; d < rhht_pkg::CAPACITY; d++) begin
               sh = table_hash[nx];
               if (sh == 0 || probe_distance(nx, sh) == 0) break;
               table_hash[stop] = sh;
               table_key[stop] = table_key[nx];
               table_val[stop] = table_val[nx];
               table_hash[nx] = 0;
               stop = nx;
               nx = (nx + 1) % rhht_pkg::CAPACITY;
            end
            if (table_count > 0) table_count--;
         end
      end
      o.entry_count = 7'(table_count);
      return o;
   endfunction

   task automatic send_request(rhht_pkg::req_type r);
      @(negedge clock);
      req_data <= r;
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(table_apply(r));
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic add_row(logic [1:0] op, logic [31:0] k, logic [31:0] h, logic [31:0] v,
                          bit typed = 0, logic [2:0] st = 0, logic [31:0] vo = 0,
                          logic [5:0] si = 0, logic [6:0] ec = 0);
      directed_row row;
      row.operation = op;
      row.key = k;
      row.key_hash = h;
      row.value = v;
      row.typed = typed;
      row.status = st;
      row.value_out = vo;
      row.slot_index = si;
      row.entry_count = ec;
      rows.push_back(row);
   endtask

   function automatic rhht_pkg::req_type random_request();
      rhht_pkg::req_type r;
      int                pick;
      pick = $urandom_range(99);
      r.value = $urandom;
      if (pick < 3) begin
         r.operation = rhht_pkg::OP_NONE;
         r.key = $urandom;
         r.key_hash = $urandom;
         return r;
      end
      r.operation = (pick < 50) ? rhht_pkg::OP_INSERT :
                    (pick < 75) ? rhht_pkg::OP_LOOKUP : rhht_pkg::OP_REMOVE;
      if (live_keys.size() > 0 && $urandom_range(3) != 0)
         r.key = live_keys[$urandom_range(live_keys.size() - 1)];
      else
         r.key = $urandom_range(1, 5) == 1 ? $urandom : $urandom_range(255);
      r.key_hash = hash_of(r.key);
      if (r.key[7:0] == 8'h00) r.key_hash = 0;
      if (r.key[7:0] == 8'h01) r.key_hash = 32'hFFFF_FFC0 | r.key[5:0];
      if (r.operation == rhht_pkg::OP_INSERT) live_keys.push_back(r.key);
      if (live_keys.size() > 200) live_keys.delete(0);
      return r;
   endfunction

   always @(negedge clock) begin
      if (long_stall) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(3) != 0) || (($urandom_range(1000) & 32'h40) != 0);
   end

   always @(posedge clock) begin
      rhht_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data !== e) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected %p, got %p", e, rsp_data);
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT && !long_stall) begin
         $display("watchdog expired");
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      rhht_pkg::req_type r;
      rhht_pkg::rsp_type e;
      int                n, burst, i, k;
      for (i = 0; i < rhht_pkg::CAPACITY; i++) begin
         table_hash[i] = 0;
         table_key[i] = 0;
         table_val[i] = 0;
      end
      table_count = 0;

      add_row(rhht_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 1, rhht_pkg::ST_NOT_FOUND, 0, 0, 0);
      add_row(rhht_pkg::OP_REMOVE, 32'h5, 32'h5, 32'h0, 1, rhht_pkg::ST_NOT_FOUND, 0, 0, 0);
      add_row(rhht_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
              rhht_pkg::ST_NOT_FOUND, 0, 0, 0);
      add_row(rhht_pkg::OP_INSERT, 32'h0, 32'h0, 32'hFFFF_FFFF, 1,
              rhht_pkg::ST_INSERTED, 0, 1, 1);
      add_row(rhht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1,
              rhht_pkg::ST_INSERTED, 0, 63, 2);
      add_row(rhht_pkg::OP_INSERT, 32'h1234, 32'h1, 32'hA5A5_5A5A);
      add_row(rhht_pkg::OP_INSERT, 32'h5678, 32'h41, 32'h5A5A_A5A5);
      add_row(rhht_pkg::OP_INSERT, 32'h9ABC, 32'h2, 32'h1111_2222);
      add_row(rhht_pkg::OP_INSERT, 32'hDEF0, 32'hFFFF_FFFF, 32'h3333_4444);
      add_row(rhht_pkg::OP_LOOKUP, 32'h5678, 32'h41, 32'h0);
      add_row(rhht_pkg::OP_LOOKUP, 32'h9ABC, 32'h2, 32'h0);
      add_row(rhht_pkg::OP_INSERT, 32'h1234, 32'h1, 32'h0BAD_F00D);
      add_row(rhht_pkg::OP_LOOKUP, 32'h7777, 32'h1, 32'h0);
      add_row(rhht_pkg::OP_REMOVE, 32'h0, 32'h1, 32'h0);
      add_row(rhht_pkg::OP_LOOKUP, 32'h5678, 32'h41, 32'h0);
      add_row(rhht_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      add_row(rhht_pkg::OP_LOOKUP, 32'hDEF0, 32'hFFFF_FFFF, 32'h0);
      add_row(rhht_pkg::OP_REMOVE, 32'h9ABC, 32'h2, 32'h0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (rows[j]) begin
         r.operation = rows[j].operation;
         r.key = rows[j].key;
         r.key_hash = rows[j].key_hash;
         r.value = rows[j].value;
         send_request(r);
         if (rows[j].typed) begin
            e.status = rows[j].status;
            e.value_out = rows[j].value_out;
            e.slot_index = rows[j].slot_index;
            e.entry_count = rows[j].entry_count;
            if (e !== pending_rsp[$]) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("table row %0d predicts %p", j, pending_rsp[$]);
            end
         end
      end

      // Fill the table past capacity so that the full status is reached.
      for (k = 0; k < rhht_pkg::CAPACITY + 3; k++) begin
         r.operation = rhht_pkg::OP_INSERT;
         r.key = 32'h8000_0000 + k;
         r.key_hash = $urandom;
         r.value = $urandom;
         send_request(r);
      end
      while (pending_rsp.size() > 0) @(posedge clock);
      for (k = 0; k < rhht_pkg::CAPACITY + 3; k++) begin
         r.operation = rhht_pkg::OP_REMOVE;
         r.key = 32'h8000_0000 + k;
         r.key_hash = $urandom;
         r.value = 0;
         send_request(r);
      end

      n = 0;
      while (n < N_RANDOM) begin
         burst = $urandom_range(1, 20);
         for (i = 0; i < burst && n < N_RANDOM; i++, n++) begin
            if (n == 300) begin
               fork
                  begin
                     long_stall = 1;
                     repeat (200) @(posedge clock);
                     long_stall = 0;
                  end
               join_none
            end
            if (n == 600)
               while (pending_rsp.size() > 0) @(posedge clock);
            send_request(random_request());
         end
         if ($urandom_range(2) == 0) repeat ($urandom_range(1, 12)) @(negedge clock);
      end

      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
`default_nettype wire
